// ----- hdl/smer_pkg.sv -----
package smer_pkg;

   typedef enum logic [0:0] {
      FUNC_INSERT = 1'b0,
      FUNC_SEARCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_MATCH     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] match_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
   } pair_type;

endpackage

// ----- hdl/smer_mem.sv -----
module smer_mem
   import smer_pkg::*;
#(
   parameter int Depth = 64,
   parameter int AddrW = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  pair_type         wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output pair_type         rd_data
);

   pair_type mem [Depth];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sorted_multimap_equal_range_lookup_top.sv -----
// Sorted multimap of up to TABLE_DEPTH (key, value) pairs held in one
// single-port-read, single-port-write memory, kept in ascending order by key
// then value. Start an item with start high while busy is low; each result
// appears for one cycle with rsp_valid high and cannot be stalled, so the
// receiver must take every strobe. With n stored pairs:
// insert walks the table from the top down, reading entry i and writing it
// to i+1 until the insert point is found, with a read state and a compare
// state per entry visited; a full table drops the pair and reports full.
// search scans all n entries, a read state and a compare state each, holding
// each match until the next one is found or the scan ends, so the final one
// is marked last; no match reports not found. Every entry takes a read state
// and a compare state because the memory read is registered and is not
// issued ahead. The table needs no clearing after reset: only entries below
// the count are ever compared.
module sorted_multimap_equal_range_lookup_top
   import smer_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [CntW-1:0]  count_ff;
   // walking index: entry currently being read
   logic [CntW-1:0]  idx_ff;
   req_type          req_ff;
   logic             found_ff;
   // pending match held one step so the final one can be marked last
   logic             pend_ff;
   logic [31:0]      pend_val_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   pair_type         wr_data;
   logic [AddrW-1:0] rd_addr;
   pair_type         rd_data;
   logic             rd_le;

   smer_mem #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stored pair at or below the new pair: insert point is just above it
   assign rd_le = (rd_data.key < req_ff.key) ||
                  ((rd_data.key == req_ff.key) && (rd_data.value <= req_ff.value));

   assign rd_addr = idx_ff[AddrW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AddrW-1:0];
      wr_data = rd_data;
      if (state_ff == ST_INS_CMP) begin
         wr_en = 1'b1;
         if (rd_le) begin
            wr_addr = AddrW'(idx_ff + 1'b1);
            wr_data = '{key: req_ff.key, value: req_ff.value};
         end else begin
            wr_addr = AddrW'(idx_ff + 1'b1);
            wr_data = rd_data;
         end
      end else if (state_ff == ST_INS_RD && idx_ff == '1) begin
         // walked past the bottom: new pair goes to entry zero
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '{key: req_ff.key, value: req_ff.value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= start && (req_item.func == FUNC_INSERT) &&
                               (count_ff == CntW'(TABLE_DEPTH));
               if (start) begin
                  req_ff   <= req_item;
                  found_ff <= 1'b0;
                  pend_ff  <= 1'b0;
                  if (req_item.func == FUNC_INSERT) begin
                     if (count_ff == CntW'(TABLE_DEPTH)) begin
                        rsp_ff <= '{status: STATUS_FULL, match_value: '0, last: 1'b1};
                        state_ff <= ST_DONE;
                     end else begin
                        // idx all-ones marks an empty walk
                        idx_ff   <= count_ff - 1'b1;
                        state_ff <= ST_INS_RD;
                     end
                  end else begin
                     idx_ff   <= '0;
                     state_ff <= ST_SRCH_RD;
                  end
               end
            end
            ST_INS_RD: begin
               rsp_valid_ff <= (idx_ff == '1);
               if (idx_ff == '1) begin
                  count_ff     <= count_ff + 1'b1;
                  rsp_ff <= '{status: STATUS_INSERTED, match_value: '0, last: 1'b1};
                  state_ff     <= ST_DONE;
               end else begin
                  state_ff <= ST_INS_CMP;
               end
            end
            ST_INS_CMP: begin
               rsp_valid_ff <= rd_le;
               if (rd_le) begin
                  count_ff     <= count_ff + 1'b1;
                  rsp_ff <= '{status: STATUS_INSERTED, match_value: '0, last: 1'b1};
                  state_ff     <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= ST_INS_RD;
               end
            end
            ST_SRCH_RD: begin
               rsp_valid_ff <= (idx_ff >= count_ff);
               if (idx_ff >= count_ff) begin
                  // scan finished: flush held match or report absence
                  if (pend_ff) begin
                     rsp_ff <= '{status: STATUS_MATCH, match_value: pend_val_ff,
                                 last: 1'b1};
                  end else begin
                     rsp_ff <= '{status: STATUS_NOT_FOUND, match_value: '0,
                                 last: 1'b1};
                  end
                  pend_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_SRCH_CMP;
               end
            end
            ST_SRCH_CMP: begin
               rsp_valid_ff <= (rd_data.key == req_ff.key) && pend_ff;
               if (rd_data.key == req_ff.key) begin
                  found_ff    <= 1'b1;
                  pend_ff     <= 1'b1;
                  pend_val_ff <= rd_data.value;
                  if (pend_ff) begin
                     rsp_ff <= '{status: STATUS_MATCH, match_value: pend_val_ff,
                                 last: 1'b0};
                  end
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= ST_SRCH_RD;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // table never grows past its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("entry count overflow");

   // a held match implies the search has found something
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> found_ff)
      else $error("pending match without found");

   // every result that ends an item is followed by return to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (state_ff == ST_DONE))
      else $error("last result outside done state");

   // an insert result always changes the count by one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_INSERTED) |->
         (count_ff == $past(count_ff) + 1'b1))
      else $error("insert without count change");

endmodule
